// File: rtl/rcg_pkg.sv
`default_nettype none

package rcg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd1;

    localparam logic [8:0]  STRENGTH_RESET = 9'd128;
    localparam logic [8:0]  S_MAX          = 9'd256;
    localparam logic [16:0] Q16_ONE        = 17'h10000;

    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    // Luma above one half: 2 * L > 255 * 65536.
    localparam logic [23:0] BRIGHT_THRESH = 24'd8355840;

    localparam logic [6:0] K_030 = 7'd77;
    localparam logic [6:0] K_020 = 7'd51;
    localparam logic [6:0] K_015 = 7'd38;
    localparam logic [6:0] K_010 = 7'd26;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_COOL    = 3'd1,
        MODE_WARM    = 3'd2,
        MODE_TEAL    = 3'd3,
        MODE_BW      = 3'd4,
        MODE_VINTAGE = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [8:0]  s;
        logic [16:0] up30;
        logic [16:0] up20;
        logic [16:0] up15;
        logic [16:0] up10;
        logic [16:0] dn20;
        logic [16:0] dn10;
    } grade_cfg_t;

    typedef struct packed {
        logic [2:0][7:0]  src;
        logic [2:0][16:0] gain;
        logic [7:0]       luma;
        logic             blend;
        logic [7:0]       alpha;
    } chan_op_t;

    function automatic logic [15:0] strength_mul(logic [8:0] s, logic [6:0] k);
        logic [15:0] s16;
        logic [15:0] k16;
        s16 = {7'd0, s};
        k16 = {9'd0, k};
        return s16 * k16;
    endfunction

    function automatic logic [16:0] gain_up(logic [8:0] s, logic [6:0] k);
        return Q16_ONE + {1'b0, strength_mul(s, k)};
    endfunction

    function automatic logic [16:0] gain_down(logic [8:0] s, logic [6:0] k);
        return Q16_ONE - {1'b0, strength_mul(s, k)};
    endfunction

endpackage

`default_nettype wire

// File: rtl/rcg_cfg.sv
`default_nettype none

module rcg_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcg_pkg::CFG_DATA_W-1:0] cfg_data,
    output rcg_pkg::grade_cfg_t            cfg
);
    import rcg_pkg::*;

    mode_t      mode_reg;
    logic [8:0] strength_reg;
    logic [8:0] s_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NONE;
            strength_reg <= STRENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= mode_t'(cfg_data[2:0]);
                CFG_STRENGTH: strength_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_sat     = (strength_reg > S_MAX) ? S_MAX : strength_reg;
        cfg.mode  = mode_reg;
        cfg.s     = s_sat;
        cfg.up30  = gain_up(s_sat, K_030);
        cfg.up20  = gain_up(s_sat, K_020);
        cfg.up15  = gain_up(s_sat, K_015);
        cfg.up10  = gain_up(s_sat, K_010);
        cfg.dn20  = gain_down(s_sat, K_020);
        cfg.dn10  = gain_down(s_sat, K_010);
    end

endmodule

`default_nettype wire

// File: rtl/rcg_front.sv
`default_nettype none

module rcg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  rcg_pkg::grade_cfg_t cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_red,
    input  logic [7:0]          s_green,
    input  logic [7:0]          s_blue,
    input  logic [7:0]          s_alpha,
    output logic                op_valid,
    input  logic                op_ready,
    output rcg_pkg::chan_op_t   op
);
    import rcg_pkg::*;

    logic        a_valid_reg;
    logic [7:0]  a_red_reg;
    logic [7:0]  a_green_reg;
    logic [7:0]  a_blue_reg;
    logic [7:0]  a_alpha_reg;
    logic [23:0] a_lsum_reg;
    logic [23:0] a_lsum_next;
    logic        a_ready;

    logic        b_valid_reg;
    chan_op_t    b_op_reg;
    chan_op_t    b_op_next;
    logic        b_ready;
    logic        bright;

    assign b_ready = !b_valid_reg || op_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    assign a_lsum_next = 24'(LUMA_WR) * 24'(s_red)
                       + 24'(LUMA_WG) * 24'(s_green)
                       + 24'(LUMA_WB) * 24'(s_blue);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && a_ready) begin
            a_red_reg   <= s_red;
            a_green_reg <= s_green;
            a_blue_reg  <= s_blue;
            a_alpha_reg <= s_alpha;
            a_lsum_reg  <= a_lsum_next;
        end
        if (a_valid_reg && b_ready) begin
            b_op_reg <= b_op_next;
        end
    end

    assign bright = a_lsum_reg > BRIGHT_THRESH;

    always_comb begin
        b_op_next.src[CH_R]  = a_red_reg;
        b_op_next.src[CH_G]  = a_green_reg;
        b_op_next.src[CH_B]  = a_blue_reg;
        b_op_next.gain[CH_R] = Q16_ONE;
        b_op_next.gain[CH_G] = Q16_ONE;
        b_op_next.gain[CH_B] = Q16_ONE;
        b_op_next.luma       = a_lsum_reg[23:16];
        b_op_next.blend      = 1'b0;
        b_op_next.alpha      = a_alpha_reg;
        case (cfg.mode)
            MODE_COOL: begin
                b_op_next.gain[CH_R] = cfg.dn20;
                b_op_next.gain[CH_B] = cfg.up30;
            end
            MODE_WARM: begin
                b_op_next.gain[CH_R] = cfg.up30;
                b_op_next.gain[CH_G] = cfg.up10;
                b_op_next.gain[CH_B] = cfg.dn20;
            end
            MODE_TEAL: begin
                if (bright) begin
                    b_op_next.gain[CH_R] = cfg.up20;
                    b_op_next.gain[CH_G] = cfg.up10;
                end else begin
                    b_op_next.gain[CH_G] = cfg.up20;
                    b_op_next.gain[CH_B] = cfg.up20;
                end
            end
            MODE_BW: begin
                b_op_next.blend = 1'b1;
            end
            MODE_VINTAGE: begin
                b_op_next.src[CH_R]  = a_lsum_reg[23:16];
                b_op_next.src[CH_G]  = a_lsum_reg[23:16];
                b_op_next.src[CH_B]  = a_lsum_reg[23:16];
                b_op_next.gain[CH_R] = cfg.up30;
                b_op_next.gain[CH_G] = cfg.up15;
                b_op_next.gain[CH_B] = cfg.dn10;
            end
            default: ;
        endcase
    end

    assign op_valid = b_valid_reg;
    assign op       = b_op_reg;

`ifndef ASSERT_OFF
    a_bright_luma: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && bright |-> a_lsum_reg[23:16] >= 8'd127)
        else $error("bright pixel with luma below one half");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !b_ready |=> a_valid_reg && $stable(a_lsum_reg))
        else $error("first stage lost its word during a stall");
`endif

endmodule

`default_nettype wire

// File: rtl/rcg_back.sv
`default_nettype none

module rcg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  rcg_pkg::grade_cfg_t cfg,
    input  logic                op_valid,
    output logic                op_ready,
    input  rcg_pkg::chan_op_t   op,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_red,
    output logic [7:0]          m_out_green,
    output logic [7:0]          m_out_blue,
    output logic [7:0]          m_out_alpha
);
    import rcg_pkg::*;

    logic             c_valid_reg;
    logic [2:0][24:0] c_prod_reg;
    logic [2:0][15:0] c_pa_reg;
    logic [15:0]      c_pb_reg;
    logic             c_blend_reg;
    logic [7:0]       c_alpha_reg;
    logic             c_ready;

    logic [2:0][24:0] prod_next;
    logic [2:0][15:0] pa_next;
    logic [15:0]      pb_next;
    logic [8:0]       inv_s;

    logic             d_valid_reg;
    logic [2:0][7:0]  d_chan_reg;
    logic [2:0][7:0]  d_chan_next;
    logic [7:0]       d_alpha_reg;
    logic             d_ready;

    logic [2:0][16:0] blend_sum;
    logic [2:0][8:0]  chan_val;

    assign d_ready  = !d_valid_reg || m_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign op_ready = c_ready;

    always_comb begin
        inv_s   = S_MAX - cfg.s;
        pb_next = 16'(op.luma) * 16'(cfg.s);
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = 25'(op.src[i]) * 25'(op.gain[i]);
            pa_next[i]   = 16'(op.src[i]) * 16'(inv_s);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            blend_sum[i]   = {1'b0, c_pa_reg[i]} + {1'b0, c_pb_reg};
            chan_val[i]    = c_blend_reg ? blend_sum[i][16:8] : c_prod_reg[i][24:16];
            d_chan_next[i] = chan_val[i][8] ? 8'hFF : chan_val[i][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= op_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_valid && c_ready) begin
            c_prod_reg  <= prod_next;
            c_pa_reg    <= pa_next;
            c_pb_reg    <= pb_next;
            c_blend_reg <= op.blend;
            c_alpha_reg <= op.alpha;
        end
        if (c_valid_reg && d_ready) begin
            d_chan_reg  <= d_chan_next;
            d_alpha_reg <= c_alpha_reg;
        end
    end

    assign m_valid     = d_valid_reg;
    assign m_out_red   = d_chan_reg[CH_R];
    assign m_out_green = d_chan_reg[CH_G];
    assign m_out_blue  = d_chan_reg[CH_B];
    assign m_out_alpha = d_alpha_reg;

`ifndef ASSERT_OFF
    a_blend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_blend_reg |->
            !blend_sum[CH_R][16] && !blend_sum[CH_G][16] && !blend_sum[CH_B][16])
        else $error("black and white blend overflowed");

    a_mul_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !d_ready |=> c_valid_reg && $stable(c_prod_reg))
        else $error("multiply stage lost its word during a stall");
`endif

endmodule

`default_nettype wire

// File: rtl/rgb_color_grade_pixel_top.sv
`default_nettype none

// Color grading of an RGBA8 pixel stream. The block takes one pixel per clock
// while the output is not stalled and passes each pixel through its four
// register stages (luma sum, gain selection, channel multiply, clamp into the
// output register), and a stall on the output holds every stage without losing
// a word. The user must write the grade mode and strength through the
// configuration port only while no pixel is in flight; the block itself does
// not enforce this. The port is always ready and ignores unknown register indexes.
module rgb_color_grade_pixel_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_red,
    input  logic [7:0]                     s_green,
    input  logic [7:0]                     s_blue,
    input  logic [7:0]                     s_alpha,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_red,
    output logic [7:0]                     m_out_green,
    output logic [7:0]                     m_out_blue,
    output logic [7:0]                     m_out_alpha
);
    import rcg_pkg::*;

    grade_cfg_t cfg;
    chan_op_t   op;
    logic       op_valid;
    logic       op_ready;

    rcg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_red    (s_red),
        .s_green  (s_green),
        .s_blue   (s_blue),
        .s_alpha  (s_alpha),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    rcg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .op          (op),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha)
    );

endmodule

`default_nettype wire
